// File: hdl/plmh_pkg.sv
// shared constants, types and helpers for the per-label match histogram
// no dependencies; imported by plmh_ctrl, plmh_dpath and per_label_match_histogram
package plmh_pkg;

    localparam int unsigned MAX_LABELS = 256;
    localparam int unsigned COUNT_BITS = 32;
    localparam int unsigned MAX_IGNORE = 4;

    localparam int unsigned LABEL_BITS = $clog2(MAX_LABELS);
    localparam int unsigned FIELD_BITS = 8;
    localparam int unsigned OUT_BITS   = 32;
    localparam int unsigned KIND_BITS  = 2;
    localparam int unsigned NUML_BITS  = 9;
    localparam int unsigned IGNC_BITS  = 3;
    localparam int unsigned CFG_IDX_BITS  = 3;
    localparam int unsigned CFG_DATA_BITS = 9;

    typedef logic [COUNT_BITS-1:0] count_t;
    typedef logic [LABEL_BITS-1:0] index_t;
    typedef logic [FIELD_BITS-1:0] label_t;

    // request kinds
    localparam logic [KIND_BITS-1:0] KIND_PIXEL = 2'd0;
    localparam logic [KIND_BITS-1:0] KIND_READ  = 2'd1;
    localparam logic [KIND_BITS-1:0] KIND_CLEAR = 2'd2;

    // configuration register indexes
    localparam logic [CFG_IDX_BITS-1:0] CFG_LABEL_RANGE  = 3'd0;
    localparam logic [CFG_IDX_BITS-1:0] CFG_IGNORE_COUNT = 3'd1;
    localparam logic [CFG_IDX_BITS-1:0] CFG_IGNORE_BASE  = 3'd2;

    localparam logic [NUML_BITS-1:0]  LABEL_RANGE_RESET = 9'd256;
    localparam label_t                IGNORE_A_RESET    = 8'd255;

    // controller to datapath commands
    typedef struct packed {
        logic capture_pixel;  // latch a pixel request and read its counters
        logic capture_read;   // latch a read request and read its counters
        logic write;          // write back the bumped counters
        logic load_out;       // load the result register
        logic clear;          // zero one counter entry and step the clear address
    } plmh_cmd_t;

    function automatic count_t sat_inc(input count_t c);
        count_t r;
        r = (c == '1) ? c : c + count_t'(1);
        return r;
    endfunction

endpackage

// File: hdl/plmh_ctrl.sv
// controller state machine for the per-label match histogram
// depends on plmh_pkg; drives plmh_dpath through plmh_cmd_t
module plmh_ctrl (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             in_valid,
    input  logic [plmh_pkg::KIND_BITS-1:0]   kind,
    input  logic                             out_stall,
    input  logic                             clear_done,
    output logic                             in_stall,
    output logic                             out_valid,
    output plmh_pkg::plmh_cmd_t              cmd
);
    import plmh_pkg::*;

    typedef enum logic [3:0] {
        ST_IDLE   = 4'b0001,
        ST_UPDATE = 4'b0010,
        ST_REPLY  = 4'b0100,
        ST_CLEAR  = 4'b1000
    } state_t;

    state_t state_reg, state_next;
    logic   out_valid_reg, out_valid_next;
    logic   accept;

    assign in_stall  = (state_reg != ST_IDLE);
    assign out_valid = out_valid_reg;
    assign accept    = in_valid && !in_stall;

    always_comb
    begin
        state_next     = state_reg;
        out_valid_next = out_valid_reg && out_stall;
        cmd            = '0;
        case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    case (kind)
                        KIND_PIXEL:
                        begin
                            cmd.capture_pixel = 1'b1;
                            state_next        = ST_UPDATE;
                        end
                        KIND_READ:
                        begin
                            cmd.capture_read = 1'b1;
                            state_next       = ST_REPLY;
                        end
                        KIND_CLEAR:
                        begin
                            state_next = ST_CLEAR;
                        end
                        default:
                        begin
                        end
                    endcase
                end
            end
            ST_UPDATE:
            begin
                cmd.write  = 1'b1;
                state_next = ST_IDLE;
            end
            ST_REPLY:
            begin
                // wait until the result register is free
                if (!out_valid_reg || !out_stall)
                begin
                    cmd.load_out   = 1'b1;
                    out_valid_next = 1'b1;
                    state_next     = ST_IDLE;
                end
            end
            ST_CLEAR:
            begin
                // one entry of every counter memory per cycle
                cmd.clear = 1'b1;
                if (clear_done)
                    state_next = ST_IDLE;
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_CLEAR;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

endmodule

// File: hdl/plmh_dpath.sv
// datapath for the per-label match histogram: config registers, counter memories,
// label checks and result register; depends on plmh_pkg, driven by plmh_ctrl
module plmh_dpath (
    input  logic                                clk,
    input  logic                                rst_n,
    input  plmh_pkg::plmh_cmd_t                 cmd,
    input  logic                                cfg_write,
    input  logic [plmh_pkg::CFG_IDX_BITS-1:0]   cfg_index,
    input  logic [plmh_pkg::CFG_DATA_BITS-1:0]  cfg_data,
    input  logic [plmh_pkg::FIELD_BITS-1:0]     truth_label,
    input  logic [plmh_pkg::FIELD_BITS-1:0]     predicted_label,
    input  logic [plmh_pkg::FIELD_BITS-1:0]     query_label,
    output logic                                clear_done,
    output logic [plmh_pkg::OUT_BITS-1:0]       true_positive_count,
    output logic [plmh_pkg::OUT_BITS-1:0]       truth_count,
    output logic [plmh_pkg::OUT_BITS-1:0]       prediction_count
);
    import plmh_pkg::*;

    // configuration
    logic [NUML_BITS-1:0] label_range_reg;
    logic [IGNC_BITS-1:0] ignore_count_reg;
    label_t               ignore_label_reg [MAX_IGNORE];

    // counter memories
    count_t tp_mem    [MAX_LABELS];
    count_t truth_mem [MAX_LABELS];
    count_t pred_mem  [MAX_LABELS];

    count_t tp_rd_reg, truth_rd_reg, pred_rd_reg;

    index_t ta_reg, pa_reg;
    logic   wr_truth_reg, wr_tp_reg, wr_pred_reg, query_ok_reg;

    index_t clr_addr_reg, clr_addr_next;

    logic [OUT_BITS-1:0] tp_out_reg, truth_out_reg, pred_out_reg;

    index_t ta_next, pa_next;
    logic   ignored, truth_ok, pred_ok, query_ok, capture;
    count_t tp_cur, truth_cur, pred_cur;

    always_comb
    begin
        ignored = 1'b0;
        for (int i = 0; i < int'(MAX_IGNORE); i++)
        begin
            if ((32'(i) < 32'(ignore_count_reg)) && (ignore_label_reg[i] == truth_label))
                ignored = 1'b1;
        end
    end

    assign truth_ok = (32'(truth_label) < 32'(label_range_reg)) &&
                      (32'(truth_label) < MAX_LABELS);
    assign pred_ok  = (32'(predicted_label) < 32'(label_range_reg)) &&
                      (32'(predicted_label) < MAX_LABELS);
    assign query_ok = (32'(query_label) < MAX_LABELS);
    assign capture  = cmd.capture_pixel || cmd.capture_read;
    assign ta_next  = cmd.capture_read ? index_t'(query_label) : index_t'(truth_label);
    assign pa_next  = cmd.capture_read ? index_t'(query_label) : index_t'(predicted_label);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            label_range_reg  <= LABEL_RANGE_RESET;
            ignore_count_reg <= '0;
            for (int i = 0; i < int'(MAX_IGNORE); i++)
                ignore_label_reg[i] <= (i == 0) ? IGNORE_A_RESET : '0;
        end
        else if (cfg_write)
        begin
            if (cfg_index == CFG_LABEL_RANGE)
                label_range_reg <= cfg_data;
            if (cfg_index == CFG_IGNORE_COUNT)
                ignore_count_reg <= cfg_data[IGNC_BITS-1:0];
            for (int i = 0; i < int'(MAX_IGNORE); i++)
            begin
                if (cfg_index == CFG_IGNORE_BASE + CFG_IDX_BITS'(i))
                    ignore_label_reg[i] <= cfg_data[FIELD_BITS-1:0];
            end
        end
    end

    // clearing pass address, back at zero when the pass ends
    assign clear_done    = (clr_addr_reg == index_t'(MAX_LABELS - 1));
    assign clr_addr_next = clear_done ? '0 : clr_addr_reg + index_t'(1);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            clr_addr_reg <= '0;
        else if (cmd.clear)
            clr_addr_reg <= clr_addr_next;
    end

    // request capture; pixel write enables settle here
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_truth_reg <= 1'b0;
            wr_tp_reg    <= 1'b0;
            wr_pred_reg  <= 1'b0;
        end
        else if (capture)
        begin
            wr_truth_reg <= cmd.capture_pixel && !ignored && truth_ok;
            wr_tp_reg    <= cmd.capture_pixel && !ignored && truth_ok &&
                            (truth_label == predicted_label);
            wr_pred_reg  <= cmd.capture_pixel && !ignored && pred_ok;
        end
    end

    always_ff @(posedge clk)
    begin
        if (capture)
        begin
            ta_reg       <= ta_next;
            pa_reg       <= pa_next;
            query_ok_reg <= query_ok;
        end
    end

    always_ff @(posedge clk)
    begin
        if (capture)
            tp_rd_reg <= tp_mem[ta_next];
        if (cmd.clear)
            tp_mem[clr_addr_reg] <= '0;
        else if (cmd.write && wr_tp_reg)
            tp_mem[ta_reg] <= sat_inc(tp_cur);
    end

    always_ff @(posedge clk)
    begin
        if (capture)
            truth_rd_reg <= truth_mem[ta_next];
        if (cmd.clear)
            truth_mem[clr_addr_reg] <= '0;
        else if (cmd.write && wr_truth_reg)
            truth_mem[ta_reg] <= sat_inc(truth_cur);
    end

    always_ff @(posedge clk)
    begin
        if (capture)
            pred_rd_reg <= pred_mem[pa_next];
        if (cmd.clear)
            pred_mem[clr_addr_reg] <= '0;
        else if (cmd.write && wr_pred_reg)
            pred_mem[pa_reg] <= sat_inc(pred_cur);
    end

    assign tp_cur    = tp_rd_reg;
    assign truth_cur = truth_rd_reg;
    assign pred_cur  = pred_rd_reg;

    always_ff @(posedge clk)
    begin
        if (cmd.load_out)
        begin
            tp_out_reg    <= query_ok_reg ? OUT_BITS'(tp_cur)    : '0;
            truth_out_reg <= query_ok_reg ? OUT_BITS'(truth_cur) : '0;
            pred_out_reg  <= query_ok_reg ? OUT_BITS'(pred_cur)  : '0;
        end
    end

    assign true_positive_count = tp_out_reg;
    assign truth_count         = truth_out_reg;
    assign prediction_count    = pred_out_reg;

endmodule

// File: hdl/per_label_match_histogram.sv
// per-label match histogram, top level: controller plus datapath
// depends on plmh_pkg, plmh_ctrl and plmh_dpath
//
// input channel (in_valid / in_stall) carries one request: kind selects a pixel
// (truth_label, predicted_label), a read of query_label's counts, or a clear.
// output channel (out_valid / out_stall) returns the three counts of a read.
// config port (cfg_write, cfg_index, cfg_data) is to be written by the user only
// while the block is idle; the block does not enforce it. a pixel request reads
// its counters, then writes them back through the single write port of each
// counter memory. a read request captures its counters and, once the result
// register is free, loads it and raises out_valid; in_stall stays high until then.
// a clear zeroes one entry of every counter memory per cycle: in_stall stays high
// until all 256 entries are zeroed, and the next request is taken after that.
// a finished result sits in the output register while pixels keep flowing; a
// second read waits in the reply state, with in_stall high, until that register
// is taken.
// after reset the same clearing pass over all 256 entries runs with in_stall high,
// and the configuration holds its reset values.
module per_label_match_histogram (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                in_valid,
    output logic                                in_stall,
    input  logic [plmh_pkg::KIND_BITS-1:0]      kind,
    input  logic [plmh_pkg::FIELD_BITS-1:0]     truth_label,
    input  logic [plmh_pkg::FIELD_BITS-1:0]     predicted_label,
    input  logic [plmh_pkg::FIELD_BITS-1:0]     query_label,
    output logic                                out_valid,
    input  logic                                out_stall,
    output logic [plmh_pkg::OUT_BITS-1:0]       true_positive_count,
    output logic [plmh_pkg::OUT_BITS-1:0]       truth_count,
    output logic [plmh_pkg::OUT_BITS-1:0]       prediction_count,
    input  logic                                cfg_write,
    input  logic [plmh_pkg::CFG_IDX_BITS-1:0]   cfg_index,
    input  logic [plmh_pkg::CFG_DATA_BITS-1:0]  cfg_data
);
    import plmh_pkg::*;

    plmh_cmd_t cmd;
    logic      clear_done;

    plmh_ctrl u_ctrl (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (in_valid),
        .kind       (kind),
        .out_stall  (out_stall),
        .clear_done (clear_done),
        .in_stall   (in_stall),
        .out_valid  (out_valid),
        .cmd        (cmd)
    );

    plmh_dpath u_dpath (
        .clk                 (clk),
        .rst_n               (rst_n),
        .cmd                 (cmd),
        .cfg_write           (cfg_write),
        .cfg_index           (cfg_index),
        .cfg_data            (cfg_data),
        .truth_label         (truth_label),
        .predicted_label     (predicted_label),
        .query_label         (query_label),
        .clear_done          (clear_done),
        .true_positive_count (true_positive_count),
        .truth_count         (truth_count),
        .prediction_count    (prediction_count)
    );

    a_cmd_onehot: assert property (@(posedge clk) disable iff (!rst_n)
        $onehot0({cmd.capture_pixel, cmd.capture_read, cmd.write, cmd.load_out, cmd.clear}))
        else $error("more than one datapath command at once");

    a_pixel_writes_next: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.capture_pixel |=> cmd.write && in_stall)
        else $error("pixel request not written back in the next cycle");

    a_load_shows_result: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.load_out |=> out_valid)
        else $error("loaded result not presented");

    a_load_not_over_held: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.load_out |-> !(out_valid && out_stall))
        else $error("result register overwritten while held");

endmodule
